@@ rtl/core/ahc_pkg.sv @@
// Shared types and constants of the automatic headlight controller.
package ahc_pkg;

    localparam int NUM_SW = 5;
    localparam int SW_LOCK = 0;
    localparam int SW_UNLOCK = 1;
    localparam int SW_TURN = 2;
    localparam int SW_IGN = 3;
    localparam int SW_DOOR = 4;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LEVEL_W = 10;
    localparam int DT_W = 8;
    localparam int DUR_W = 16;

    localparam logic [LEVEL_W-1:0] RST_DEBOUNCE_TICKS = 10'd30;
    localparam logic [DUR_W-1:0] RST_SEQUENCE_WINDOW = 16'd4000;
    localparam logic [DUR_W-1:0] RST_COMFORT_DURATION = 16'd25000;
    localparam logic [DUR_W-1:0] RST_DOOR_HOLD_TIME = 16'd15000;
    localparam logic [DUR_W-1:0] RST_LIGHT_SETTLE_TIME = 16'd500;
    localparam logic [LEVEL_W-1:0] RST_CLEAR_THRESHOLD = 10'd750;
    localparam logic [LEVEL_W-1:0] RST_DARK_THRESHOLD = 10'd790;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS = 3'd0,
        CFG_SEQUENCE_WINDOW = 3'd1,
        CFG_COMFORT_DURATION = 3'd2,
        CFG_DOOR_HOLD_TIME = 3'd3,
        CFG_LIGHT_SETTLE_TIME = 3'd4,
        CFG_CLEAR_THRESHOLD = 3'd5,
        CFG_DARK_THRESHOLD = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic sw_edge;   // newly accepted active (low) level
        logic level;     // accepted level
    } t_lane_out;

    typedef struct packed {
        logic [DUR_W-1:0] sequence_window;
        logic [DUR_W-1:0] comfort_duration;
        logic [DUR_W-1:0] door_hold_time;
        logic [DUR_W-1:0] light_settle_time;
        logic [LEVEL_W-1:0] clear_threshold;
        logic [LEVEL_W-1:0] dark_threshold;
    } t_merge_cfg;

    typedef struct packed {
        logic headlight_on;
        logic ambient_dark;
        logic comfort_active;
        logic door_hold_active;
        logic awaiting_turn;
    } t_result;

endpackage

@@ rtl/core/ahc_debounce_lane.sv @@
// One switch debounce lane: tracks the raw level and accepts it once it holds.
module ahc_debounce_lane #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_raw,
    input  logic [ahc_pkg::DT_W-1:0]       i_dt,
    input  logic [ahc_pkg::LEVEL_W-1:0]    i_debounce_ticks,
    output ahc_pkg::t_lane_out             o_lane
);
    import ahc_pkg::*;

    localparam int TW = TIMER_WIDTH;

    logic          r_seen, n_seen;
    logic          r_accepted, n_accepted;
    logic [TW-1:0] r_age, n_age;
    logic [TW:0]   w_sum;

    always_comb begin
        w_sum = {1'b0, r_age} + (TW+1)'(i_dt);
        n_age = w_sum[TW] ? {TW{1'b1}} : w_sum[TW-1:0];
        n_seen = r_seen;
        n_accepted = r_accepted;
        o_lane.sw_edge = 1'b0;
        // restart the age on any raw change
        if (i_raw != r_seen) begin
            n_seen = i_raw;
            n_age = '0;
        end
        if (i_raw != r_accepted && n_age >= TW'(i_debounce_ticks)) begin
            n_accepted = i_raw;
            o_lane.sw_edge = i_en && !i_raw;
        end
        o_lane.level = i_en ? n_accepted : r_accepted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b1;
            r_accepted <= 1'b1;
            r_age <= '0;
        end else if (i_en) begin
            r_seen <= n_seen;
            r_accepted <= n_accepted;
            r_age <= n_age;
        end
    end

endmodule

@@ rtl/core/ahc_merge.sv @@
// Merge stage: sequence window, comfort and door timers, darkness verdict.
module ahc_merge #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [ahc_pkg::NUM_SW-1:0]     i_edges,
    input  logic                           i_ign_level,
    input  logic [ahc_pkg::LEVEL_W-1:0]    i_light,
    input  logic [ahc_pkg::DT_W-1:0]       i_dt,
    input  ahc_pkg::t_merge_cfg            i_cfg,
    output ahc_pkg::t_result               o_result
);
    import ahc_pkg::*;

    localparam int TW = TIMER_WIDTH;
    localparam int CW = (TW > DUR_W) ? TW : DUR_W;

    function automatic logic [TW-1:0] age_add(logic [TW-1:0] a, logic [DT_W-1:0] dt);
        logic [TW:0] s;
        s = {1'b0, a} + (TW+1)'(dt);
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    function automatic logic [TW-1:0] left_sub(logic [TW-1:0] a, logic [DT_W-1:0] dt);
        logic [TW-1:0] d;
        d = TW'(dt);
        return (a > d) ? a - d : '0;
    endfunction

    // clamp a register value to the timer range
    function automatic logic [TW-1:0] clampt(logic [DUR_W-1:0] v);
        logic [CW-1:0] e;
        logic [CW-1:0] m;
        e = CW'(v);
        m = CW'({TW{1'b1}});
        return (e > m) ? TW'(m) : TW'(e);
    endfunction

    logic          r_window_open, n_window_open;
    logic [TW-1:0] r_window_age, n_window_age;
    logic          r_candidate, n_candidate;
    logic [TW-1:0] r_candidate_age, n_candidate_age;
    logic          r_verdict, n_verdict;
    logic [TW-1:0] r_comfort_left, n_comfort_left;
    logic [TW-1:0] r_door_left, n_door_left;
    logic [TW-1:0] w_seq;
    logic          w_nd;

    always_comb begin
        n_window_age = age_add(r_window_age, i_dt);
        n_candidate_age = age_add(r_candidate_age, i_dt);
        n_comfort_left = left_sub(r_comfort_left, i_dt);
        n_door_left = left_sub(r_door_left, i_dt);
        n_window_open = r_window_open;
        n_candidate = r_candidate;
        n_verdict = r_verdict;
        w_seq = clampt(i_cfg.sequence_window);

        // open the window on lock or unlock
        if (i_edges[SW_LOCK] || i_edges[SW_UNLOCK]) begin
            n_window_open = 1'b1;
            n_window_age = '0;
        end
        if (i_edges[SW_TURN] && n_window_open && n_window_age <= w_seq) begin
            n_comfort_left = clampt(i_cfg.comfort_duration);
            n_window_open = 1'b0;
        end
        if (n_window_open && n_window_age > w_seq) begin
            n_window_open = 1'b0;
        end

        // hysteresis, light test first
        w_nd = r_verdict;
        if (i_light < i_cfg.clear_threshold) begin
            w_nd = 1'b0;
        end else if (i_light > i_cfg.dark_threshold) begin
            w_nd = 1'b1;
        end
        if (w_nd != r_candidate) begin
            n_candidate = w_nd;
            n_candidate_age = '0;
        end
        if (n_candidate != r_verdict
            && CW'(n_candidate_age) >= CW'(i_cfg.light_settle_time)) begin
            n_verdict = n_candidate;
        end

        if (i_edges[SW_DOOR]) begin
            n_door_left = clampt(i_cfg.door_hold_time);
        end

        o_result.comfort_active = n_comfort_left != '0;
        o_result.door_hold_active = n_door_left != '0;
        o_result.ambient_dark = n_verdict;
        o_result.awaiting_turn = n_window_open;
        o_result.headlight_on = o_result.comfort_active
            || (n_verdict && (!i_ign_level || o_result.door_hold_active));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_open <= 1'b0;
            r_window_age <= '0;
            r_candidate <= 1'b0;
            r_candidate_age <= '0;
            r_verdict <= 1'b0;
            r_comfort_left <= '0;
            r_door_left <= '0;
        end else if (i_en) begin
            r_window_open <= n_window_open;
            r_window_age <= n_window_age;
            r_candidate <= n_candidate;
            r_candidate_age <= n_candidate_age;
            r_verdict <= n_verdict;
            r_comfort_left <= n_comfort_left;
            r_door_left <= n_door_left;
        end
    end

endmodule

@@ rtl/core/auto_headlight_controller_unit.sv @@
// Top level of the automatic headlight controller: lanes, merge stage, output buffer.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): one beat is one sample of the five
//   active-low switch lines, the 10-bit light reading and the milliseconds since
//   the previous sample. A beat is taken at a rising edge with valid high and
//   stall low.
//   Output channel (o_out_valid / i_out_stall): one result beat per input beat,
//   in order, carrying the lamp drive and four status flags.
//   Configuration (i_cfg_valid / o_cfg_ready): index 0..6 selects the register,
//   i_cfg_data carries the value; o_cfg_ready is always high and unknown
//   indexes are dropped. Write only while the block is idle.
// Throughput: one beat per cycle while the output is not stalled; the result of a
//   beat is registered in the output register, or parked in the skid stage while the output is held,
//   and the five debounce lanes and the merge stage update their state as the beat is taken.
// Reset (i_rst_n low, synchronous): registers return to their defaults, all
//   switches read inactive, timers clear and both channels empty.
// Stall: a result held by the receiver stays stable; one further result is
//   parked in a skid stage, and only then is o_in_stall raised.
module auto_headlight_controller_unit #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_lock_level,
    input  logic                              i_unlock_level,
    input  logic                              i_turn_level,
    input  logic                              i_ignition_level,
    input  logic                              i_door_level,
    input  logic [ahc_pkg::LEVEL_W-1:0]       i_light_sample,
    input  logic [ahc_pkg::DT_W-1:0]          i_ms_elapsed,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_headlight_on,
    output logic                              o_ambient_dark,
    output logic                              o_comfort_active,
    output logic                              o_door_hold_active,
    output logic                              o_awaiting_turn,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [ahc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ahc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import ahc_pkg::*;

    // configuration registers
    logic [LEVEL_W-1:0] r_debounce_ticks;
    t_merge_cfg         r_cfg;

    logic               w_in_accept;
    logic               w_out_take;
    logic [NUM_SW-1:0]  w_raw;
    logic [NUM_SW-1:0]  w_edges;
    t_lane_out          w_lane [NUM_SW];
    t_result            w_result;

    // output register and skid stage
    t_result            r_out, n_out;
    t_result            r_skid, n_skid;
    logic               r_out_valid, n_out_valid;
    logic               r_skid_valid, n_skid_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks <= RST_DEBOUNCE_TICKS;
            r_cfg.sequence_window <= RST_SEQUENCE_WINDOW;
            r_cfg.comfort_duration <= RST_COMFORT_DURATION;
            r_cfg.door_hold_time <= RST_DOOR_HOLD_TIME;
            r_cfg.light_settle_time <= RST_LIGHT_SETTLE_TIME;
            r_cfg.clear_threshold <= RST_CLEAR_THRESHOLD;
            r_cfg.dark_threshold <= RST_DARK_THRESHOLD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DEBOUNCE_TICKS: r_debounce_ticks <= i_cfg_data[LEVEL_W-1:0];
                CFG_SEQUENCE_WINDOW: r_cfg.sequence_window <= i_cfg_data;
                CFG_COMFORT_DURATION: r_cfg.comfort_duration <= i_cfg_data;
                CFG_DOOR_HOLD_TIME: r_cfg.door_hold_time <= i_cfg_data;
                CFG_LIGHT_SETTLE_TIME: r_cfg.light_settle_time <= i_cfg_data;
                CFG_CLEAR_THRESHOLD: r_cfg.clear_threshold <= i_cfg_data[LEVEL_W-1:0];
                CFG_DARK_THRESHOLD: r_cfg.dark_threshold <= i_cfg_data[LEVEL_W-1:0];
                default: begin
                    // drop writes to unknown indexes
                end
            endcase
        end
    end

    // Take a beat whenever the skid stage is free.
    assign o_in_stall = r_skid_valid;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_take = r_out_valid && !i_out_stall;

    // bit order: lock, unlock, turn, ignition, door
    assign w_raw = {i_door_level, i_ignition_level, i_turn_level, i_unlock_level, i_lock_level};

    // One debounce lane per switch, all advancing on the same beat.
    for (genvar g = 0; g < NUM_SW; g++) begin : g_lane
        ahc_debounce_lane #(
            .TIMER_WIDTH(TIMER_WIDTH)
        ) u_lane (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_en            (w_in_accept),
            .i_raw           (w_raw[g]),
            .i_dt            (i_ms_elapsed),
            .i_debounce_ticks(r_debounce_ticks),
            .o_lane          (w_lane[g])
        );
        assign w_edges[g] = w_lane[g].sw_edge;
    end

    // Combine the lane edges with the timers and the darkness verdict.
    ahc_merge #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_in_accept),
        .i_edges    (w_edges),
        .i_ign_level(w_lane[SW_IGN].level),
        .i_light    (i_light_sample),
        .i_dt       (i_ms_elapsed),
        .i_cfg      (r_cfg),
        .o_result   (w_result)
    );

    always_comb begin
        n_out = r_out;
        n_skid = r_skid;
        n_out_valid = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            // no beat is taken here; advance the parked result once the output frees
            if (w_out_take) begin
                n_out = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (w_in_accept) begin
            if (!r_out_valid || w_out_take) begin
                n_out = w_result;
                n_out_valid = 1'b1;
            end else begin
                // receiver holds the output: park the new result
                n_skid = w_result;
                n_skid_valid = 1'b1;
            end
        end else if (w_out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_headlight_on = r_out.headlight_on;
    assign o_ambient_dark = r_out.ambient_dark;
    assign o_comfort_active = r_out.comfort_active;
    assign o_door_hold_active = r_out.door_hold_active;
    assign o_awaiting_turn = r_out.awaiting_turn;

    // a parked result always has one waiting ahead of it
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds a result while the output register is empty");

    // the skid stage fills only behind a stalled output
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid stage filled while the output was free");

    // outside comfort mode the lamp needs darkness
    a_lamp_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_headlight_on && !o_comfort_active) |-> o_ambient_dark)
        else $error("headlight on in daylight without comfort mode");

endmodule
